// ----- src/command_frame_parser_sum_check_assert.svh -----
// Assertion macros shared by the frame parser RTL.
`ifndef COMMAND_FRAME_PARSER_SUM_CHECK_ASSERT_SVH
`define COMMAND_FRAME_PARSER_SUM_CHECK_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CFPSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfpsc assertion failed");

// Next-cycle implication, checked outside reset.
`define CFPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfpsc assertion failed");

`endif

// ----- src/cfpsc_pkg.sv -----
package cfpsc_pkg;

  // Default for the largest declared length plus one.
  localparam int LENGTH_LIMIT_DEF = 50;

  // Frame framing bytes.
  localparam logic [7:0] SYNC_A     = 8'hAA;
  localparam logic [7:0] SYNC_B     = 8'hAF;
  localparam logic [7:0] TYPE_LIMIT = 8'hF1;

  // Command type codes.
  localparam logic [7:0] TYPE_CAL      = 8'h01;
  localparam logic [7:0] TYPE_PID_REQ  = 8'h02;
  localparam logic [7:0] TYPE_LED      = 8'h03;
  localparam logic [7:0] TYPE_PID_LD0  = 8'h10;
  localparam logic [7:0] TYPE_PID_LD1  = 8'h11;
  localparam logic [7:0] TYPE_ACK0     = 8'h12;
  localparam logic [7:0] TYPE_ACK1     = 8'h13;
  localparam logic [7:0] TYPE_ACK2     = 8'h14;
  localparam logic [7:0] TYPE_ACK3     = 8'h15;
  localparam logic [7:0] TYPE_STOP     = 8'h21;
  localparam logic [7:0] TYPE_SET_MODE = 8'h22;
  localparam logic [7:0] TYPE_POSITION = 8'h24;

  // First payload byte codes.
  localparam logic [7:0] ARG_ACC_CAL   = 8'h01;
  localparam logic [7:0] ARG_GYRO_CAL  = 8'h02;
  localparam logic [7:0] ARG_BOTH_CAL  = 8'h03;
  localparam logic [7:0] ARG_MAG_CAL   = 8'h04;
  localparam logic [7:0] ARG_SAVE      = 8'h05;
  localparam logic [7:0] ARG_PID_READ  = 8'h01;
  localparam logic [7:0] ARG_FACTORY   = 8'hA1;

  // Decoded action codes.
  localparam logic [3:0] ACT_NONE     = 4'd0;
  localparam logic [3:0] ACT_ACC_CAL  = 4'd1;
  localparam logic [3:0] ACT_GYRO_CAL = 4'd2;
  localparam logic [3:0] ACT_BOTH_CAL = 4'd3;
  localparam logic [3:0] ACT_MAG_CAL  = 4'd4;
  localparam logic [3:0] ACT_SAVE     = 4'd5;
  localparam logic [3:0] ACT_SET_MODE = 4'd6;
  localparam logic [3:0] ACT_STOP     = 4'd7;
  localparam logic [3:0] ACT_POSITION = 4'd8;
  localparam logic [3:0] ACT_PID_READ = 4'd9;
  localparam logic [3:0] ACT_FACTORY  = 4'd10;
  localparam logic [3:0] ACT_PID_LOAD = 4'd11;
  localparam logic [3:0] ACT_ACK_ONLY = 4'd12;
  localparam logic [3:0] ACT_LED      = 4'd13;

  // One result word as held in the output register.
  typedef struct packed {
    logic       kind;
    logic [7:0] frame_type;
    logic [5:0] byte_index;
    logic [7:0] data_byte;
    logic [5:0] frame_length;
    logic       sum_ok;
    logic [7:0] computed_sum;
    logic [3:0] action;
    logic [7:0] mode_value;
    logic       ack_request;
  } result_t;

endpackage

// ----- src/cfpsc_action_dec.sv -----
// Maps a frame type and its first payload byte to a command action.
module cfpsc_action_dec (
  input  logic [7:0] frame_type,
  input  logic [7:0] first_byte,
  output logic [3:0] action
);

  always_comb begin
    action = cfpsc_pkg::ACT_NONE;
    unique case (frame_type)
      cfpsc_pkg::TYPE_CAL: begin
        unique case (first_byte)
          cfpsc_pkg::ARG_ACC_CAL:  action = cfpsc_pkg::ACT_ACC_CAL;
          cfpsc_pkg::ARG_GYRO_CAL: action = cfpsc_pkg::ACT_GYRO_CAL;
          cfpsc_pkg::ARG_BOTH_CAL: action = cfpsc_pkg::ACT_BOTH_CAL;
          cfpsc_pkg::ARG_MAG_CAL:  action = cfpsc_pkg::ACT_MAG_CAL;
          cfpsc_pkg::ARG_SAVE:     action = cfpsc_pkg::ACT_SAVE;
          default:                 action = cfpsc_pkg::ACT_NONE;
        endcase
      end
      cfpsc_pkg::TYPE_PID_REQ: begin
        unique case (first_byte)
          cfpsc_pkg::ARG_PID_READ: action = cfpsc_pkg::ACT_PID_READ;
          cfpsc_pkg::ARG_FACTORY:  action = cfpsc_pkg::ACT_FACTORY;
          default:                 action = cfpsc_pkg::ACT_NONE;
        endcase
      end
      cfpsc_pkg::TYPE_SET_MODE: action = cfpsc_pkg::ACT_SET_MODE;
      cfpsc_pkg::TYPE_STOP:     action = cfpsc_pkg::ACT_STOP;
      cfpsc_pkg::TYPE_POSITION: action = cfpsc_pkg::ACT_POSITION;
      cfpsc_pkg::TYPE_PID_LD0,
      cfpsc_pkg::TYPE_PID_LD1:  action = cfpsc_pkg::ACT_PID_LOAD;
      cfpsc_pkg::TYPE_ACK0,
      cfpsc_pkg::TYPE_ACK1,
      cfpsc_pkg::TYPE_ACK2,
      cfpsc_pkg::TYPE_ACK3:     action = cfpsc_pkg::ACT_ACK_ONLY;
      cfpsc_pkg::TYPE_LED:      action = cfpsc_pkg::ACT_LED;
      default:                  action = cfpsc_pkg::ACT_NONE;
    endcase
  end

endmodule

// ----- src/command_frame_parser_sum_check.sv -----
// Byte-stream command frame parser. Each input word is one received byte; the block hunts
// for frames of the form 0xAA, 0xAF, type (below 0xF1), length (below LENGTH_LIMIT),
// payload bytes and an 8-bit sum of everything before it. Every payload byte is passed on
// as a word of kind 0, and the sum byte yields one frame-end word of kind 1 with the
// type, length, check result, decoded command action and acknowledge request. Sync,
// header and out-of-place bytes produce no word. The block takes one byte per clock:
// the parser state and the next result are formed combinationally and the result is
// registered, so a word appears on the output in the cycle after its byte is taken. The
// only thing that holds the input back is a full output register whose word is stalled
// downstream; while the output register drains, a new byte is taken in the same cycle.
`include "command_frame_parser_sum_check_assert.svh"

module command_frame_parser_sum_check #(
  parameter int LENGTH_LIMIT = cfpsc_pkg::LENGTH_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input byte channel.
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  // Result channel.
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_frame_type,
  output logic [5:0] out_byte_index,
  output logic [7:0] out_data_byte,
  output logic [5:0] out_frame_length,
  output logic       out_sum_ok,
  output logic [7:0] out_computed_sum,
  output logic [3:0] out_action,
  output logic [7:0] out_mode_value,
  output logic       out_ack_request
);

  // Parser phases, one per expected frame element.
  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_SYNC_B  = 3'd1;
  localparam logic [2:0] PH_TYPE    = 3'd2;
  localparam logic [2:0] PH_LENGTH  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_SUM     = 3'd5;

  localparam logic [7:0] LEN_LIMIT_B = 8'(LENGTH_LIMIT);

  logic [2:0] phase_r, phase_nxt;
  logic [5:0] bytes_left_r, bytes_left_nxt;
  logic [5:0] payload_count_r, payload_count_nxt;
  logic [5:0] declared_length_r, declared_length_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic [7:0] held_type_r, held_type_nxt;
  logic [7:0] first_payload_r, first_payload_nxt;

  cfpsc_pkg::result_t res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               res_fire;
  logic               in_accept;
  logic               sum_match;
  logic               ack_type;
  logic [3:0]         dec_action;

  // A byte is taken unless a finished word is sitting stalled in the output register.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  cfpsc_action_dec u_action_dec (
    .frame_type (held_type_r),
    .first_byte (first_payload_r),
    .action     (dec_action)
  );

  assign sum_match = (running_sum_r == in_rx_byte);
  assign ack_type  = (held_type_r >= cfpsc_pkg::TYPE_PID_LD0) &&
                     (held_type_r <= cfpsc_pkg::TYPE_ACK3);

  // Next parser state and the result word, if this byte produces one.
  always_comb begin
    phase_nxt           = phase_r;
    bytes_left_nxt      = bytes_left_r;
    payload_count_nxt   = payload_count_r;
    declared_length_nxt = declared_length_r;
    running_sum_nxt     = running_sum_r;
    held_type_nxt       = held_type_r;
    first_payload_nxt   = first_payload_r;
    res_fire            = 1'b0;
    res_nxt             = '0;

    unique case (phase_r)
      PH_HUNT: begin
        if (in_rx_byte == cfpsc_pkg::SYNC_A) begin
          phase_nxt       = PH_SYNC_B;
          running_sum_nxt = cfpsc_pkg::SYNC_A;
        end
      end
      PH_SYNC_B: begin
        if (in_rx_byte == cfpsc_pkg::SYNC_B) begin
          phase_nxt       = PH_TYPE;
          running_sum_nxt = running_sum_r + in_rx_byte;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_TYPE: begin
        if (in_rx_byte < cfpsc_pkg::TYPE_LIMIT) begin
          phase_nxt       = PH_LENGTH;
          held_type_nxt   = in_rx_byte;
          running_sum_nxt = running_sum_r + in_rx_byte;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_LENGTH: begin
        if (in_rx_byte < LEN_LIMIT_B) begin
          phase_nxt           = PH_PAYLOAD;
          declared_length_nxt = in_rx_byte[5:0];
          bytes_left_nxt      = in_rx_byte[5:0];
          payload_count_nxt   = '0;
          first_payload_nxt   = '0;
          running_sum_nxt     = running_sum_r + in_rx_byte;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        // A zero-length frame lands here with nothing left; that byte is dropped.
        if (bytes_left_r != '0) begin
          if (payload_count_r == '0) begin
            first_payload_nxt = in_rx_byte;
          end
          running_sum_nxt   = running_sum_r + in_rx_byte;
          bytes_left_nxt    = bytes_left_r - 6'd1;
          payload_count_nxt = payload_count_r + 6'd1;
          if (bytes_left_r == 6'd1) begin
            phase_nxt = PH_SUM;
          end
          res_fire             = 1'b1;
          res_nxt.kind         = 1'b0;
          res_nxt.frame_type   = held_type_r;
          res_nxt.byte_index   = payload_count_r;
          res_nxt.data_byte    = in_rx_byte;
          res_nxt.frame_length = declared_length_r;
          res_nxt.sum_ok       = 1'b0;
          res_nxt.computed_sum = running_sum_nxt;
          res_nxt.action       = cfpsc_pkg::ACT_NONE;
          res_nxt.mode_value   = first_payload_nxt;
          res_nxt.ack_request  = 1'b0;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_SUM: begin
        // The frame-end word is given whether or not the sum matches.
        phase_nxt            = PH_HUNT;
        res_fire             = 1'b1;
        res_nxt.kind         = 1'b1;
        res_nxt.frame_type   = held_type_r;
        res_nxt.byte_index   = '0;
        res_nxt.data_byte    = in_rx_byte;
        res_nxt.frame_length = declared_length_r;
        res_nxt.sum_ok       = sum_match;
        res_nxt.computed_sum = running_sum_r;
        res_nxt.action       = sum_match ? dec_action : cfpsc_pkg::ACT_NONE;
        res_nxt.mode_value   = first_payload_r;
        res_nxt.ack_request  = sum_match && ack_type;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_comb begin
    if (in_accept && res_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_HUNT;
      bytes_left_r      <= '0;
      payload_count_r   <= '0;
      declared_length_r <= '0;
      running_sum_r     <= '0;
      held_type_r       <= '0;
      first_payload_r   <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        phase_r           <= phase_nxt;
        bytes_left_r      <= bytes_left_nxt;
        payload_count_r   <= payload_count_nxt;
        declared_length_r <= declared_length_nxt;
        running_sum_r     <= running_sum_nxt;
        held_type_r       <= held_type_nxt;
        first_payload_r   <= first_payload_nxt;
      end
    end
  end

  // The result word itself carries no reset; out_valid_r qualifies it.
  always_ff @(posedge clk) begin
    if (in_accept && res_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = res_r.kind;
  assign out_frame_type   = res_r.frame_type;
  assign out_byte_index   = res_r.byte_index;
  assign out_data_byte    = res_r.data_byte;
  assign out_frame_length = res_r.frame_length;
  assign out_sum_ok       = res_r.sum_ok;
  assign out_computed_sum = res_r.computed_sum;
  assign out_action       = res_r.action;
  assign out_mode_value   = res_r.mode_value;
  assign out_ack_request  = res_r.ack_request;

  // Payload counters always add up to the declared length.
  `CFPSC_ASSERT_SAME(a_payload_count, clk, rst_n, phase_r == PH_PAYLOAD, 6'(payload_count_r + bytes_left_r) == declared_length_r)
  // Any decoded action or acknowledge request only comes with a good frame end.
  `CFPSC_ASSERT_SAME(a_action_needs_sum, clk, rst_n, out_valid_r && (res_r.action != cfpsc_pkg::ACT_NONE || res_r.ack_request), res_r.kind && res_r.sum_ok)
  // A payload word's position stays inside the declared length.
  `CFPSC_ASSERT_SAME(a_index_in_frame, clk, rst_n, out_valid_r && !res_r.kind, res_r.byte_index < res_r.frame_length)
  // Taking the sum byte always returns the parser to hunting and posts a word.
  `CFPSC_ASSERT_NEXT(a_sum_ends_frame, clk, rst_n, in_accept && phase_r == PH_SUM, phase_r == PH_HUNT && out_valid_r && res_r.kind)

endmodule

// ----- tb/frame_word_checker.sv -----
module frame_word_checker #(
  parameter int LENGTH_LIMIT = cfpsc_pkg::LENGTH_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_kind,
  input  logic [7:0] out_frame_type,
  input  logic [5:0] out_byte_index,
  input  logic [7:0] out_data_byte,
  input  logic [5:0] out_frame_length,
  input  logic       out_sum_ok,
  input  logic [7:0] out_computed_sum,
  input  logic [3:0] out_action,
  input  logic [7:0] out_mode_value,
  input  logic       out_ack_request,
  output int         mismatch_count,
  output int         pending_count,
  output int         words_checked,
  output int         frame_ends,
  output int         good_frames
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT, PH_SYNC_B, PH_TYPE, PH_LENGTH, PH_PAYLOAD, PH_SUM
  } parse_phase_e;

  // Shadow copy of the parser state.
  parse_phase_e phase;
  logic [5:0]   bytes_left;
  logic [5:0]   payload_count;
  logic [5:0]   declared_length;
  logic [7:0]   running_sum;
  logic [7:0]   held_type;
  logic [7:0]   first_payload;

  cfpsc_pkg::result_t expected_words[$];
  int                 mismatches;
  int                 checked;
  int                 ends;
  int                 goods;

  function automatic string word_text(input cfpsc_pkg::result_t w);
    return $sformatf({"kind=%0d type=%02h idx=%0d data=%02h len=%0d ok=%0d sum=%02h",
                      " act=%0d mode=%02h ack=%0d"},
                     w.kind, w.frame_type, w.byte_index, w.data_byte, w.frame_length,
                     w.sum_ok, w.computed_sum, w.action, w.mode_value, w.ack_request);
  endfunction

  always @(posedge clk) begin
    cfpsc_pkg::result_t seen;
    cfpsc_pkg::result_t want;
    cfpsc_pkg::result_t word;
    logic [7:0]         b;
    logic [3:0]         act;
    logic               ok;
    if (!rst_n) begin
      phase           = PH_HUNT;
      bytes_left      = '0;
      payload_count   = '0;
      declared_length = '0;
      running_sum     = '0;
      held_type       = '0;
      first_payload   = '0;
      expected_words.delete();
      mismatches      = 0;
      checked         = 0;
      ends            = 0;
      goods           = 0;
    end else begin
      // Compare first: a word leaving now was caused by an earlier byte.
      if (out_valid && !out_stall) begin
        seen = {out_kind, out_frame_type, out_byte_index, out_data_byte, out_frame_length,
                out_sum_ok, out_computed_sum, out_action, out_mode_value, out_ack_request};
        if (expected_words.size() == 0) begin
          if (mismatches < 10) begin
            $display("[%0t] unexpected word: %s", $realtime, word_text(seen));
          end
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (seen !== want) begin
            if (mismatches < 10) begin
              $display("[%0t] word mismatch\n  expected %s\n  actual   %s",
                       $realtime, word_text(want), word_text(seen));
            end
            mismatches++;
          end
          checked++;
          if (want.kind == KIND_FRAME_END) begin
            ends++;
            if (want.sum_ok) begin
              goods++;
            end
          end
        end
      end

      if (in_valid && !in_stall) begin
        b = in_rx_byte;
        if (phase == PH_HUNT && b == cfpsc_pkg::SYNC_A) begin
          phase       = PH_SYNC_B;
          running_sum = cfpsc_pkg::SYNC_A;
        end else if (phase == PH_SYNC_B && b == cfpsc_pkg::SYNC_B) begin
          phase       = PH_TYPE;
          running_sum = running_sum + b;
        end else if (phase == PH_TYPE && b < cfpsc_pkg::TYPE_LIMIT) begin
          phase       = PH_LENGTH;
          held_type   = b;
          running_sum = running_sum + b;
        end else if (phase == PH_LENGTH && b < LENGTH_LIMIT && b < 64) begin
          phase           = PH_PAYLOAD;
          declared_length = b[5:0];
          bytes_left      = b[5:0];
          payload_count   = '0;
          first_payload   = '0;
          running_sum     = running_sum + b;
        end else if (phase == PH_PAYLOAD && bytes_left != 0) begin
          if (payload_count == 0) begin
            first_payload = b;
          end
          running_sum       = running_sum + b;
          bytes_left        = bytes_left - 6'd1;
          word              = '0;
          word.kind         = KIND_PAYLOAD;
          word.frame_type   = held_type;
          word.byte_index   = payload_count;
          word.data_byte    = b;
          word.frame_length = declared_length;
          word.computed_sum = running_sum;
          word.mode_value   = first_payload;
          expected_words.push_back(word);
          payload_count = payload_count + 6'd1;
          if (bytes_left == 0) begin
            phase = PH_SUM;
          end
        end else if (phase == PH_SUM) begin
          ok  = (running_sum == b);
          act = cfpsc_pkg::ACT_NONE;
          if (ok) begin
            case (held_type)
              cfpsc_pkg::TYPE_CAL: begin
                case (first_payload)
                  cfpsc_pkg::ARG_ACC_CAL:  act = cfpsc_pkg::ACT_ACC_CAL;
                  cfpsc_pkg::ARG_GYRO_CAL: act = cfpsc_pkg::ACT_GYRO_CAL;
                  cfpsc_pkg::ARG_BOTH_CAL: act = cfpsc_pkg::ACT_BOTH_CAL;
                  cfpsc_pkg::ARG_MAG_CAL:  act = cfpsc_pkg::ACT_MAG_CAL;
                  cfpsc_pkg::ARG_SAVE:     act = cfpsc_pkg::ACT_SAVE;
                  default:                 act = cfpsc_pkg::ACT_NONE;
                endcase
              end
              cfpsc_pkg::TYPE_SET_MODE: act = cfpsc_pkg::ACT_SET_MODE;
              cfpsc_pkg::TYPE_STOP:     act = cfpsc_pkg::ACT_STOP;
              cfpsc_pkg::TYPE_POSITION: act = cfpsc_pkg::ACT_POSITION;
              cfpsc_pkg::TYPE_PID_REQ: begin
                if (first_payload == cfpsc_pkg::ARG_PID_READ) begin
                  act = cfpsc_pkg::ACT_PID_READ;
                end else if (first_payload == cfpsc_pkg::ARG_FACTORY) begin
                  act = cfpsc_pkg::ACT_FACTORY;
                end
              end
              cfpsc_pkg::TYPE_PID_LD0, cfpsc_pkg::TYPE_PID_LD1:
                act = cfpsc_pkg::ACT_PID_LOAD;
              cfpsc_pkg::TYPE_ACK0, cfpsc_pkg::TYPE_ACK1, cfpsc_pkg::TYPE_ACK2,
              cfpsc_pkg::TYPE_ACK3:
                act = cfpsc_pkg::ACT_ACK_ONLY;
              cfpsc_pkg::TYPE_LED: act = cfpsc_pkg::ACT_LED;
              default:             act = cfpsc_pkg::ACT_NONE;
            endcase
          end
          word              = '0;
          word.kind         = KIND_FRAME_END;
          word.frame_type   = held_type;
          word.data_byte    = b;
          word.frame_length = declared_length;
          word.sum_ok       = ok;
          word.computed_sum = running_sum;
          word.action       = act;
          word.mode_value   = first_payload;
          word.ack_request  = ok && held_type >= cfpsc_pkg::TYPE_PID_LD0 &&
                              held_type <= cfpsc_pkg::TYPE_ACK3;
          expected_words.push_back(word);
          phase = PH_HUNT;
        end else begin
          phase = PH_HUNT;
        end
      end
    end
    mismatch_count <= mismatches;
    pending_count  <= expected_words.size();
    words_checked  <= checked;
    frame_ends     <= ends;
    good_frames    <= goods;
  end

endmodule

// ----- tb/tb_command_frame_parser_sum_check.sv -----
module tb_command_frame_parser_sum_check;
  timeunit 1ns;
  timeprecision 1ps;

  // Roughly this many random bytes go out inside frame attempts; the loose noise
  // bytes that the parser simply drops come on top of it.
  localparam int RANDOM_BYTES = 1000;
  // The limit covers the slowest legal run (every byte and every word held off
  // by the longest burst) and leaves ample room.
  localparam int CYCLE_LIMIT  = 300000;
  // The block answers in the cycle after a byte; this margin covers any late word.
  localparam int SETTLE       = 10;

  localparam logic [7:0] COMMAND_TYPES [12] = '{
    cfpsc_pkg::TYPE_CAL, cfpsc_pkg::TYPE_PID_REQ, cfpsc_pkg::TYPE_LED,
    cfpsc_pkg::TYPE_PID_LD0, cfpsc_pkg::TYPE_PID_LD1, cfpsc_pkg::TYPE_ACK0,
    cfpsc_pkg::TYPE_ACK1, cfpsc_pkg::TYPE_ACK2, cfpsc_pkg::TYPE_ACK3,
    cfpsc_pkg::TYPE_STOP, cfpsc_pkg::TYPE_SET_MODE, cfpsc_pkg::TYPE_POSITION
  };
  localparam logic [7:0] COMMAND_ARGS [7] = '{
    cfpsc_pkg::ARG_ACC_CAL, cfpsc_pkg::ARG_GYRO_CAL, cfpsc_pkg::ARG_BOTH_CAL,
    cfpsc_pkg::ARG_MAG_CAL, cfpsc_pkg::ARG_SAVE, cfpsc_pkg::ARG_PID_READ,
    cfpsc_pkg::ARG_FACTORY
  };

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic       out_kind;
  logic [7:0] out_frame_type;
  logic [5:0] out_byte_index;
  logic [7:0] out_data_byte;
  logic [5:0] out_frame_length;
  logic       out_sum_ok;
  logic [7:0] out_computed_sum;
  logic [3:0] out_action;
  logic [7:0] out_mode_value;
  logic       out_ack_request;

  int mismatch_count;
  int pending_count;
  int words_checked;
  int frame_ends;
  int good_frames;

  // Idling intensity on each side, in sixteenths: 0 means no idling at all.
  int send_gap_level = 0;
  int stall_level    = 0;
  int stall_left     = 0;
  int bytes_sent     = 0;
  int frame_bytes    = 0;
  int cycle_count    = 0;

  command_frame_parser_sum_check dut (.*);

  // The checker watches both channels, predicts every word and compares.
  frame_word_checker word_check (.*);

  always #4 clk = ~clk;

  // Watchdog: a hung handshake or a word that never arrives ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The receiver holds the result channel off in bursts of random length. The
  // burst start is random, so stalls land on payload words and frame ends alike.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_level != 0 && $urandom_range(0, 15) < stall_level) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one byte and hold it until the block takes it. When no gap follows, valid
  // simply stays high and the next call only changes the data. A gap drops valid
  // for a random burst, which can fall in any phase of the frame.
  task automatic push_byte(input logic [7:0] b);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (send_gap_level != 0 && $urandom_range(0, 15) < send_gap_level) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Send a complete frame. The first payload byte is given so command arguments can
  // be steered; the rest are random. A nonzero sum_error corrupts the check byte.
  // With a length of zero the check byte becomes the byte the parser throws away.
  task automatic push_frame(input logic [7:0] ftype, input logic [5:0] len,
                            input logic [7:0] first, input logic [7:0] sum_error);
    logic [7:0] sum;
    logic [7:0] b;
    sum = cfpsc_pkg::SYNC_A;
    sum = sum + cfpsc_pkg::SYNC_B;
    sum = sum + ftype;
    sum = sum + {2'b00, len};
    push_byte(cfpsc_pkg::SYNC_A);
    push_byte(cfpsc_pkg::SYNC_B);
    push_byte(ftype);
    push_byte({2'b00, len});
    for (int k = 0; k < len; k++) begin
      b   = (k == 0) ? first : 8'($urandom_range(0, 255));
      sum = sum + b;
      push_byte(b);
    end
    push_byte(sum + sum_error);
    frame_bytes += len + 5;
  endtask

  // Stop sending and wait until every predicted word has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] ftype;
    logic [7:0] first;
    logic [7:0] sum_error;
    logic [5:0] len;
    int         pick;
    int         random_end;
    bit         paused;
    paused = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with light idling on both sides.
    send_gap_level = 3;
    stall_level    = 3;
    // A repeated first sync byte is consumed as out of place, so the 0xAF that
    // follows lands in the hunting phase and must be ignored.
    push_byte(cfpsc_pkg::SYNC_A);
    push_byte(cfpsc_pkg::SYNC_A);
    push_byte(cfpsc_pkg::SYNC_B);
    // Zero-length frame: nothing is reported and the byte after the length is eaten.
    push_frame(cfpsc_pkg::TYPE_LED, 6'd0, 8'h00, 8'h00);
    // Type byte at the limit breaks the header.
    push_byte(cfpsc_pkg::SYNC_A);
    push_byte(cfpsc_pkg::SYNC_B);
    push_byte(cfpsc_pkg::TYPE_LIMIT);
    // Length byte at the limit breaks the header.
    push_byte(cfpsc_pkg::SYNC_A);
    push_byte(cfpsc_pkg::SYNC_B);
    push_byte(cfpsc_pkg::TYPE_CAL);
    push_byte(8'(cfpsc_pkg::LENGTH_LIMIT_DEF));
    // Highest legal type with an all-ones payload and a good sum.
    push_frame(cfpsc_pkg::TYPE_LIMIT - 8'd1, 6'd1, 8'hFF, 8'h00);
    // A set-mode frame with a bad check byte still reports, with no action.
    push_frame(cfpsc_pkg::TYPE_SET_MODE, 6'd1, 8'h07, 8'h01);
    // Let the block run dry before the random part starts.
    wait_drained();

    // Random part. Most attempts are well-formed frames with random content, the
    // rest are loose noise and broken headers. Idling levels change now and then,
    // including stretches with none, and the final stretch runs without idling.
    frame_bytes = 0;
    random_end  = RANDOM_BYTES;
    while (frame_bytes < random_end) begin
      if (frame_bytes >= random_end - 150) begin
        send_gap_level = 0;
        stall_level    = 0;
      end else if ($urandom_range(0, 14) == 0) begin
        send_gap_level = $urandom_range(0, 4);
        stall_level    = $urandom_range(0, 4);
      end
      // Halfway through, the sender waits once for the block to empty out.
      if (!paused && frame_bytes >= random_end / 2) begin
        paused = 1'b1;
        wait_drained();
      end

      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        case ($urandom_range(0, 3))
          0, 1:    ftype = COMMAND_TYPES[4'($urandom_range(0, 11))];
          2:       ftype = 8'($urandom_range(0, cfpsc_pkg::TYPE_LIMIT - 1));
          default: ftype = $urandom_range(0, 1) ? cfpsc_pkg::TYPE_LIMIT - 8'd1 : 8'h00;
        endcase
        case ($urandom_range(0, 19))
          0:       len = 6'($urandom_range(cfpsc_pkg::LENGTH_LIMIT_DEF - 2,
                                           cfpsc_pkg::LENGTH_LIMIT_DEF - 1));
          1, 2, 3: len = 6'($urandom_range(5, 16));
          default: len = 6'($urandom_range(1, 4));
        endcase
        first     = $urandom_range(0, 1) ? COMMAND_ARGS[3'($urandom_range(0, 6))]
                                         : 8'($urandom_range(0, 255));
        sum_error = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        push_frame(ftype, len, first, sum_error);
      end else if (pick < 82) begin
        // Loose noise, with a fair share of sync bytes among it.
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0:       push_byte(cfpsc_pkg::SYNC_A);
            1:       push_byte(cfpsc_pkg::SYNC_B);
            default: push_byte(8'($urandom_range(0, 255)));
          endcase
        end
      end else if (pick < 94) begin
        // A header that breaks at a random point.
        push_byte(cfpsc_pkg::SYNC_A);
        case ($urandom_range(0, 2))
          0: push_byte(8'($urandom_range(0, 255)));
          1: begin
            push_byte(cfpsc_pkg::SYNC_B);
            push_byte(8'($urandom_range(cfpsc_pkg::TYPE_LIMIT, 255)));
          end
          default: begin
            push_byte(cfpsc_pkg::SYNC_B);
            push_byte(8'($urandom_range(0, cfpsc_pkg::TYPE_LIMIT - 1)));
            push_byte(8'($urandom_range(cfpsc_pkg::LENGTH_LIMIT_DEF, 255)));
          end
        endcase
        frame_bytes += 3;
      end else begin
        push_frame(8'($urandom_range(0, cfpsc_pkg::TYPE_LIMIT - 1)), 6'd0,
                   8'h00, 8'($urandom_range(0, 255)));
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d bytes covering frames of every command type and length range,",
             bytes_sent);
    $display("broken headers and noise; %0d words checked, %0d frame ends (%0d good sums).",
             words_checked, frame_ends, good_frames);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
